// ----- hw/rtl/bdeq_pkg.sv -----
`default_nettype none
package bdeq_pkg;

  localparam int DEPTH  = 64;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;
  localparam int CAP_W  = 7;
  localparam int KIND_W = 2;

  localparam logic [KIND_W-1:0] KIND_INS_FRONT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_INS_BACK  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DEL_FRONT = 2'd2;
  localparam logic [KIND_W-1:0] KIND_DEL_BACK  = 2'd3;

  // output tdata layout, lowest bit first
  localparam int OUT_BITS = 1 + DATA_W + DATA_W + 1 + 1 + CNT_W;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic [CNT_W-1:0]  entry_count;
    logic              is_full;
    logic              is_empty;
    logic [DATA_W-1:0] rear_value;
    logic [DATA_W-1:0] front_value;
    logic              ok;
  } res_t;

endpackage
`default_nettype wire

// ----- hw/rtl/bdeq_ram.sv -----
`default_nettype none
module bdeq_ram
  import bdeq_pkg::*;
(
  input  wire logic              clk,
  input  wire mem_req_t          req,
  output logic     [DATA_W-1:0]  rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rd_data <= mem[req.raddr];
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/bdeq_ctrl.sv -----
`default_nettype none
module bdeq_ctrl
  import bdeq_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [CAP_W-1:0]  capacity,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [KIND_W-1:0] kind,
  input  wire logic [DATA_W-1:0] value,
  output mem_req_t               mem_req,
  input  wire logic [DATA_W-1:0] rd_data,
  output logic                   res_valid,
  input  wire logic              res_ready,
  output res_t                   res
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_RD   = 1'b1;

  logic              state;
  logic [ADDR_W-1:0] head;
  logic [CNT_W-1:0]  occ;
  logic [DATA_W-1:0] front_q;
  logic [DATA_W-1:0] rear_q;
  logic              ok_q;
  logic              pend_front;
  logic              pend_rear;

  logic [ADDR_W-1:0] head_next;
  logic [CNT_W-1:0]  occ_next;
  logic [DATA_W-1:0] front_next;
  logic [DATA_W-1:0] rear_next;
  logic              ok_next;
  logic              pend_front_next;
  logic              pend_rear_next;

  logic [CNT_W-1:0]  cap_eff;
  logic              full;
  logic              empty;
  logic              accept;
  logic              finish;
  logic [DATA_W-1:0] front_cur;
  logic [DATA_W-1:0] rear_cur;

  always_comb begin
    if (CNT_W'(capacity) > CNT_W'(DEPTH)) begin
      cap_eff = CNT_W'(DEPTH);
    end else begin
      cap_eff = CNT_W'(capacity);
    end
  end

  assign full     = occ >= cap_eff;
  assign empty    = occ == '0;
  assign in_ready = state == S_IDLE;
  assign accept   = in_valid && in_ready;
  assign finish   = (state == S_RD) && res_ready;

  // Inserts write the new end directly and cache it; deletes fetch the new end.
  always_comb begin
    head_next       = head;
    occ_next        = occ;
    front_next      = front_q;
    rear_next       = rear_q;
    ok_next         = 1'b0;
    pend_front_next = 1'b0;
    pend_rear_next  = 1'b0;
    mem_req         = '0;
    mem_req.wdata   = value;
    case (kind)
      KIND_INS_FRONT: begin
        if (!full) begin
          head_next     = head - ADDR_W'(1);
          occ_next      = occ + CNT_W'(1);
          front_next    = value;
          if (empty) begin
            rear_next = value;
          end
          ok_next       = 1'b1;
          mem_req.we    = accept;
          mem_req.waddr = head - ADDR_W'(1);
        end
      end
      KIND_INS_BACK: begin
        if (!full) begin
          occ_next      = occ + CNT_W'(1);
          rear_next     = value;
          if (empty) begin
            front_next = value;
          end
          ok_next       = 1'b1;
          mem_req.we    = accept;
          mem_req.waddr = head + occ[ADDR_W-1:0];
        end
      end
      KIND_DEL_FRONT: begin
        if (!empty) begin
          head_next       = head + ADDR_W'(1);
          occ_next        = occ - CNT_W'(1);
          ok_next         = 1'b1;
          pend_front_next = 1'b1;
          mem_req.re      = accept;
          mem_req.raddr   = head + ADDR_W'(1);
        end
      end
      default: begin
        if (!empty) begin
          occ_next       = occ - CNT_W'(1);
          ok_next        = 1'b1;
          pend_rear_next = 1'b1;
          mem_req.re     = accept;
          mem_req.raddr  = head + occ[ADDR_W-1:0] - ADDR_W'(2);
        end
      end
    endcase
  end

  // Read data stays valid in S_RD since no new read is issued there.
  assign front_cur = pend_front ? rd_data : front_q;
  assign rear_cur  = pend_rear ? rd_data : rear_q;

  assign res_valid       = state == S_RD;
  assign res.ok          = ok_q;
  assign res.front_value = empty ? '0 : front_cur;
  assign res.rear_value  = empty ? '0 : rear_cur;
  assign res.is_empty    = empty;
  assign res.is_full     = full;
  assign res.entry_count = occ;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      head       <= '0;
      occ        <= '0;
      ok_q       <= 1'b0;
      pend_front <= 1'b0;
      pend_rear  <= 1'b0;
    end else if (accept) begin
      state      <= S_RD;
      head       <= head_next;
      occ        <= occ_next;
      ok_q       <= ok_next;
      pend_front <= pend_front_next;
      pend_rear  <= pend_rear_next;
    end else if (finish) begin
      state      <= S_IDLE;
      pend_front <= 1'b0;
      pend_rear  <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      front_q <= front_next;
      rear_q  <= rear_next;
    end else if (finish) begin
      front_q <= front_cur;
      rear_q  <= rear_cur;
    end
  end

`ifndef SYNTHESIS
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= CNT_W'(DEPTH))
    else $error("occupancy above store depth");

  a_occ_step: assert property (@(posedge clk) disable iff (rst)
    accept |=> (occ == $past(occ) + CNT_W'(1)) || (occ == $past(occ) - CNT_W'(1))
               || (occ == $past(occ) && !ok_q))
    else $error("occupancy moved by more than one entry");

  a_hold_no_accept: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(occ) && $stable(head))
    else $error("pointer state changed without a transfer");

  a_one_access: assert property (@(posedge clk) disable iff (rst)
    !(mem_req.we && mem_req.re))
    else $error("store read and written by the same item");

  a_fetch_then_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> res_valid)
    else $error("accepted item did not reach the result stage");
`endif

endmodule
`default_nettype wire

// ----- hw/rtl/bounded_double_ended_queue.sv -----
`default_nettype none
// Bounded double-ended queue of signed 32-bit values held in a 64-entry circular
// store. Each s_tuser kind inserts at the front or back or deletes at the front or
// back; each transfer yields one result with the success flag, the front and rear
// values (0 when empty), empty and full flags and the entry count. Capacity is
// written on the cfg channel (reset 64, values above 64 act as 64, 0 blocks all
// inserts) and may be written only while the queue is idle. Each item first
// updates the pointers and issues the store access, then waits in the result
// state for the store's registered read to return a new end value after a delete.
// A new item is taken while the previous result waits in the output register.
module bounded_double_ended_queue
  import bdeq_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [CAP_W-1:0]  cfg_data,   // capacity
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire logic [DATA_W-1:0] s_tdata,    // value
  input  wire logic [KIND_W-1:0] s_tuser,    // kind
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  // ok, front_value, rear_value, is_empty, is_full, entry_count, zero fill
  output logic [OUT_W-1:0]       m_tdata
);

  logic [CAP_W-1:0]  capacity;
  mem_req_t          mem_req;
  logic [DATA_W-1:0] rd_data;
  logic              res_valid;
  logic              res_ready;
  res_t              res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_W'(DEPTH);
    end else if (cfg_valid && cfg_ready) begin
      capacity <= cfg_data;
    end
  end

  bdeq_ram u_ram (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  bdeq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .capacity  (capacity),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .kind      (s_tuser),
    .value     (s_tdata),
    .mem_req   (mem_req),
    .rd_data   (rd_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      m_tdata <= OUT_W'(res);
    end
  end

endmodule
`default_nettype wire
